FILE: sv/rbfa_pkg.sv
package rbfa_pkg;

  localparam int NUM_BANKS  = 256;
  localparam int BANK_BYTES = 16384;

  localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int FREE_W = $clog2(BANK_BYTES + 1);
  localparam int BNUM_W = 8;
  localparam int SIZE_W = 16;
  localparam int STAT_W = 3;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [BNUM_W-1:0] AUTO_BANK   = 8'hFF;
  localparam logic [BNUM_W-1:0] MBC1_EXCL_A = 8'h20;
  localparam logic [BNUM_W-1:0] MBC1_EXCL_B = 8'h40;
  localparam logic [BNUM_W-1:0] MBC1_EXCL_C = 8'h60;
  localparam logic [BNUM_W-1:0] LAST_INDEX  = BNUM_W'(NUM_BANKS - 1);
  localparam logic [BNUM_W:0]   BANK_COUNT  = (BNUM_W + 1)'(NUM_BANKS);
  localparam logic [FREE_W-1:0] FULL_FREE   = FREE_W'(BANK_BYTES);
  localparam logic [SIZE_W-1:0] SIZE_LIMIT  = SIZE_W'(BANK_BYTES);

  typedef enum logic [1:0] {
    KIND_UNSET = 2'd0,
    KIND_CODE  = 2'd1,
    KIND_LIT   = 2'd2
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_PLACED    = 3'd0,
    ST_OVERFULL  = 3'd1,
    ST_OUT_RANGE = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_MIXED     = 3'd4,
    ST_NO_BANK   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_FIRST_BANK = 2'd0,
    REG_LAST_BANK  = 2'd1,
    REG_MBC1_MODE  = 2'd2,
    REG_FORBID_MIX = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [BNUM_W-1:0] first_bank;
    logic [BNUM_W-1:0] last_bank;
    logic              mbc1_mode;
    logic              forbid_mixing;
  } cfg_t;

  typedef struct packed {
    logic    load_in;
    logic    rd_fixed;
    logic    rd_scan;
    logic    scan_init;
    logic    commit;
    logic    mark_all;
    logic    set_res;
    logic    res_placed;
    status_t res_code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic too_large;
    logic is_auto;
    logic fix_in_range;
    logic range_empty;
    logic scan_at_end;
    logic rd_valid;
    logic rd_last;
    logic entry_pass;
    logic kind_ok;
    logic over;
    logic out_free;
  } sts_t;

  function automatic logic mbc1_excluded(input logic [BNUM_W-1:0] b);
    return (b == MBC1_EXCL_A) || (b == MBC1_EXCL_B) || (b == MBC1_EXCL_C);
  endfunction

endpackage

FILE: sv/rbfa_regs.sv
module rbfa_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rbfa_pkg::ADDR_W-1:0] paddr,
  input  logic [rbfa_pkg::DATA_W-1:0] pwdata,
  output logic [rbfa_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output rbfa_pkg::cfg_t              cfg
);
  import rbfa_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_bank    <= 8'd1;
      cfg.last_bank     <= 8'd255;
      cfg.mbc1_mode     <= 1'b0;
      cfg.forbid_mixing <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_FIRST_BANK: cfg.first_bank    <= pwdata[BNUM_W-1:0];
        REG_LAST_BANK:  cfg.last_bank     <= pwdata[BNUM_W-1:0];
        REG_MBC1_MODE:  cfg.mbc1_mode     <= pwdata[0];
        REG_FORBID_MIX: cfg.forbid_mixing <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FIRST_BANK: prdata = DATA_W'(cfg.first_bank);
      REG_LAST_BANK:  prdata = DATA_W'(cfg.last_bank);
      REG_MBC1_MODE:  prdata = DATA_W'(cfg.mbc1_mode);
      REG_FORBID_MIX: prdata = DATA_W'(cfg.forbid_mixing);
      default:        prdata = '0;
    endcase
  end

endmodule

FILE: sv/rbfa_ctrl.sv
module rbfa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  rbfa_pkg::sts_t sts,
  output rbfa_pkg::cmd_t cmd
);
  import rbfa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECIDE = 5'b00010,
    S_FIXCHK = 5'b00100,
    S_SCAN   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   issue_done, issue_done_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      issue_done <= 1'b0;
    end else begin
      state      <= state_next;
      issue_done <= issue_done_next;
    end
  end

  always_comb begin
    cmd             = '0;
    state_next      = state;
    issue_done_next = issue_done;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (sts.too_large) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_TOO_LARGE;
          state_next   = S_DONE;
        end else if (!sts.is_auto && sts.fix_in_range) begin
          cmd.rd_fixed = 1'b1;
          state_next   = S_FIXCHK;
        end else if (!sts.is_auto) begin
          cmd.mark_all = 1'b1;
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_OUT_RANGE;
          state_next   = S_DONE;
        end else if (sts.range_empty) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_NO_BANK;
          state_next   = S_DONE;
        end else begin
          cmd.scan_init   = 1'b1;
          issue_done_next = 1'b0;
          state_next      = S_SCAN;
        end
      end
      S_FIXCHK: begin
        cmd.set_res = 1'b1;
        state_next  = S_DONE;
        if (!sts.kind_ok) begin
          cmd.res_code = ST_MIXED;
        end else begin
          cmd.commit     = 1'b1;
          cmd.res_placed = 1'b1;
          cmd.res_code   = sts.over ? ST_OVERFULL : ST_PLACED;
        end
      end
      S_SCAN: begin
        // Reads are issued one bank a cycle; each bank is checked in the cycle after its read.
        if (!issue_done) begin
          cmd.rd_scan = 1'b1;
          if (sts.scan_at_end) issue_done_next = 1'b1;
        end
        if (sts.rd_valid && sts.entry_pass) begin
          cmd.commit     = 1'b1;
          cmd.set_res    = 1'b1;
          cmd.res_placed = 1'b1;
          cmd.res_code   = ST_PLACED;
          state_next     = S_DONE;
        end else if (sts.rd_valid && sts.rd_last) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_NO_BANK;
          state_next   = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_commit_then_done: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (state == S_DONE))
    else $error("commit not followed by result stage");

endmodule

FILE: sv/rbfa_dpath.sv
module rbfa_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  rbfa_pkg::cfg_t              cfg,
  input  rbfa_pkg::cmd_t              cmd,
  output rbfa_pkg::sts_t              sts,
  input  logic [rbfa_pkg::BNUM_W-1:0] bank_request,
  input  logic [rbfa_pkg::SIZE_W-1:0] area_size,
  input  logic                        area_kind,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rbfa_pkg::STAT_W-1:0] status,
  output logic [rbfa_pkg::BNUM_W-1:0] bank_assigned,
  output logic                        mbc1_warning,
  output logic [rbfa_pkg::BNUM_W-1:0] lowest_assigned,
  output logic [rbfa_pkg::BNUM_W-1:0] highest_assigned,
  output logic [rbfa_pkg::BNUM_W-1:0] highest_any
);
  import rbfa_pkg::*;

  logic [BNUM_W-1:0] req;
  logic [SIZE_W-1:0] size;
  kind_t             code;

  logic [FREE_W-1:0] free_mem [NUM_BANKS];
  kind_t             kind_mem [NUM_BANKS];
  logic [NUM_BANKS-1:0] entry_valid;

  logic              rd_en;
  logic [BNUM_W-1:0] rd_addr;
  logic [FREE_W-1:0] rd_free;
  kind_t             rd_kind;
  logic              rd_entry_valid;
  logic              rd_valid;
  logic [BNUM_W-1:0] rd_bank;
  logic              rd_last;

  logic [BNUM_W-1:0] scan_addr;
  logic [BNUM_W-1:0] scan_end;

  logic [FREE_W-1:0] cur_free;
  kind_t             cur_kind;
  logic              kind_ok;
  logic              over;
  logic [FREE_W-1:0] free_next;

  logic [BNUM_W-1:0] low_mark, high_mark, high_mark_all;
  status_t           res_status;
  logic [BNUM_W-1:0] res_bank;
  logic              res_warn;
  logic              out_free;

  assign scan_end = (cfg.last_bank > LAST_INDEX) ? LAST_INDEX : cfg.last_bank;
  assign rd_en    = cmd.rd_fixed || cmd.rd_scan;
  assign rd_addr  = cmd.rd_fixed ? req : scan_addr;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req  <= bank_request;
      size <= area_size;
      code <= area_kind ? KIND_LIT : KIND_CODE;
    end
    if (cmd.scan_init) begin
      scan_addr <= cfg.first_bank;
    end else if (cmd.rd_scan) begin
      scan_addr <= scan_addr + 8'd1;
    end
  end

  // Bank table: one registered read and one write per cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_free        <= free_mem[rd_addr[BANK_W-1:0]];
      rd_kind        <= kind_mem[rd_addr[BANK_W-1:0]];
      rd_entry_valid <= entry_valid[rd_addr[BANK_W-1:0]];
      rd_bank        <= rd_addr;
      rd_last        <= cmd.rd_scan && (rd_addr == scan_end);
    end
    if (cmd.commit) begin
      free_mem[rd_bank[BANK_W-1:0]] <= free_next;
      kind_mem[rd_bank[BANK_W-1:0]] <= code;
    end
  end

  // A bank never written reads as empty and of no kind.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      if (cmd.commit) entry_valid[rd_bank[BANK_W-1:0]] <= 1'b1;
    end
  end

  assign cur_free  = rd_entry_valid ? rd_free : FULL_FREE;
  assign cur_kind  = rd_entry_valid ? rd_kind : KIND_UNSET;
  assign kind_ok   = !(cfg.forbid_mixing && (cur_kind != KIND_UNSET) && (cur_kind != code));
  assign over      = size > SIZE_W'(cur_free);
  assign free_next = over ? '0 : (cur_free - size[FREE_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      low_mark      <= 8'd255;
      high_mark     <= 8'd0;
      high_mark_all <= 8'd0;
    end else if (cmd.commit) begin
      if (rd_bank < low_mark)      low_mark      <= rd_bank;
      if (rd_bank > high_mark)     high_mark     <= rd_bank;
      if (rd_bank > high_mark_all) high_mark_all <= rd_bank;
    end else if (cmd.mark_all) begin
      if (req > high_mark_all) high_mark_all <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_status <= cmd.res_code;
      res_bank   <= cmd.res_placed ? rd_bank : AUTO_BANK;
      res_warn   <= cmd.res_placed && (req != AUTO_BANK) && cfg.mbc1_mode
                    && mbc1_excluded(rd_bank);
    end
  end

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status           <= res_status;
      bank_assigned    <= res_bank;
      mbc1_warning     <= res_warn;
      lowest_assigned  <= low_mark;
      highest_assigned <= high_mark;
      highest_any      <= high_mark_all;
    end
  end

  always_comb begin
    sts.too_large    = size > SIZE_LIMIT;
    sts.is_auto      = (req == AUTO_BANK);
    sts.fix_in_range = (req >= cfg.first_bank) && (req <= cfg.last_bank)
                       && ({1'b0, req} < BANK_COUNT);
    sts.range_empty  = cfg.first_bank > scan_end;
    sts.scan_at_end  = (scan_addr == scan_end);
    sts.rd_valid     = rd_valid;
    sts.rd_last      = rd_last;
    sts.entry_pass   = !(cfg.mbc1_mode && mbc1_excluded(rd_bank)) && kind_ok && !over;
    sts.kind_ok      = kind_ok;
    sts.over         = over;
    sts.out_free     = out_free;
  end

  a_commit_has_data: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> rd_valid)
    else $error("bank written without read data");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result register overwritten while stalled");

  a_marks_order: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.commit) |-> (low_mark <= high_mark))
    else $error("low mark above high mark after placement");

endmodule

FILE: sv/rom_bank_first_fit_allocator_unit.sv
// First-fit ROM bank allocator.
// The input channel (in_valid/in_stall) carries one area request per transfer:
// bank_request (255 asks for automatic placement), area_size and area_kind.
// The output channel (out_valid/out_stall) returns one result per request:
// status, bank_assigned, mbc1_warning and the low/high bank marks after it.
// The APB port holds first_bank, last_bank, mbc1_mode and forbid_mixing at
// byte addresses 0, 4, 8 and 12; write it only while no request is in flight.
// A request that is too large, names an out-of-range fixed bank or finds an empty
// bank range is answered from the decision step; a fixed bank in range is first
// read from the bank table and then checked; an automatic request scans banks from
// first_bank (up to 256) until one fits. The bank table has one read port, so the
// scan reads one bank per cycle; this loop sets the rate. A new request is
// accepted once the result is in the output register, even while the receiver
// stalls; if that result is still held when the next one is ready, the block waits.
// Reset clears all banks to full and unset kind at once through per-bank
// valid bits, sets the marks to 255/0/0 and loads the register defaults.
module rom_bank_first_fit_allocator_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rbfa_pkg::BNUM_W-1:0] bank_request,
  input  logic [rbfa_pkg::SIZE_W-1:0] area_size,
  input  logic                        area_kind,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rbfa_pkg::STAT_W-1:0] status,
  output logic [rbfa_pkg::BNUM_W-1:0] bank_assigned,
  output logic                        mbc1_warning,
  output logic [rbfa_pkg::BNUM_W-1:0] lowest_assigned,
  output logic [rbfa_pkg::BNUM_W-1:0] highest_assigned,
  output logic [rbfa_pkg::BNUM_W-1:0] highest_any,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rbfa_pkg::ADDR_W-1:0] paddr,
  input  logic [rbfa_pkg::DATA_W-1:0] pwdata,
  output logic [rbfa_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import rbfa_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  rbfa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rbfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rbfa_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cmd              (cmd),
    .sts              (sts),
    .bank_request     (bank_request),
    .area_size        (area_size),
    .area_kind        (area_kind),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .bank_assigned    (bank_assigned),
    .mbc1_warning     (mbc1_warning),
    .lowest_assigned  (lowest_assigned),
    .highest_assigned (highest_assigned),
    .highest_any      (highest_any)
  );

endmodule
